@@ hdl/tpsf_pkg.sv @@
// Shared types, constants and helpers of the track point smoothing filter.
package tpsf_pkg;

  localparam int IO_W            = 32;
  localparam int MODE_W          = 3;
  localparam int COORD_BITS_DEF  = 32;
  localparam int COEF_FRAC_DEF   = 16;

  localparam logic [MODE_W-1:0] MODE_MEAN3  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD5  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BELL3  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BELL5  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LIGHT3 = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PASS   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RESET  = MODE_LIGHT3;

  localparam int CNT_W = 3;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int MAX_RES    = 3;
  localparam int NRES_W     = 2;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [IO_W-1:0] x;
    logic signed [IO_W-1:0] y;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic [NRES_W-1:0]        n;
    res_t [MAX_RES-1:0]       item;
  } push_t;

  typedef struct packed {
    logic             space_ok;
    logic [LVL_W-1:0] level;
  } fifo_stat_t;

  function automatic logic [1:0] half_width(input logic [MODE_W-1:0] mode);
    logic [1:0] h;
    unique case (mode)
      MODE_MEAN3, MODE_BELL3, MODE_LIGHT3: h = 2'd1;
      MODE_QUAD5, MODE_BELL5:              h = 2'd2;
      default:                             h = 2'd0;
    endcase
    return h;
  endfunction

endpackage

@@ hdl/tpsf_if.sv @@
// Point request channels: input points and smoothed result points.
interface tpsf_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [tpsf_pkg::IO_W-1:0] x_in;
  logic signed [tpsf_pkg::IO_W-1:0] y_in;
  logic                           last_in;

  modport source (output valid, x_in, y_in, last_in, input ready);
  modport sink   (input valid, x_in, y_in, last_in, output ready);
endinterface

interface tpsf_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [tpsf_pkg::IO_W-1:0] x_out;
  logic signed [tpsf_pkg::IO_W-1:0] y_out;
  logic                           last_out;

  modport source (output valid, x_out, y_out, last_out, input ready);
  modport sink   (input valid, x_out, y_out, last_out, output ready);
endinterface

@@ hdl/tpsf_axis.sv @@
// One-axis weighted sum with rounding and saturation for the smoothing modes.
module tpsf_axis #(
  parameter int COORD_BITS     = tpsf_pkg::COORD_BITS_DEF,
  parameter int COEF_FRAC_BITS = tpsf_pkg::COEF_FRAC_DEF
) (
  input  logic [tpsf_pkg::MODE_W-1:0] mode,
  input  logic signed [((COORD_BITS > tpsf_pkg::IO_W) ? COORD_BITS : tpsf_pkg::IO_W)-1:0] s2,
  input  logic signed [((COORD_BITS > tpsf_pkg::IO_W) ? COORD_BITS : tpsf_pkg::IO_W)-1:0] s1,
  input  logic signed [tpsf_pkg::IO_W-1:0] r0,
  input  logic signed [tpsf_pkg::IO_W-1:0] r1,
  input  logic signed [tpsf_pkg::IO_W-1:0] r2,
  output logic signed [((COORD_BITS > tpsf_pkg::IO_W) ? COORD_BITS : tpsf_pkg::IO_W)-1:0] filt
);

  localparam int HIST_W = (COORD_BITS > tpsf_pkg::IO_W) ? COORD_BITS : tpsf_pkg::IO_W;
  localparam int F      = COEF_FRAC_BITS;
  localparam int ACC_W  = HIST_W + F + 6;
  localparam int QW     = ACC_W - F;

  localparam logic signed [ACC_W-1:0] C_1_3    = ACC_W'(((64'sd1 <<< F) + 1) / 3);
  localparam logic signed [ACC_W-1:0] C_12_35  = ACC_W'(((64'sd12 <<< F) + 17) / 35);
  localparam logic signed [ACC_W-1:0] C_3_35   = ACC_W'(((64'sd3 <<< F) + 17) / 35);
  localparam logic signed [ACC_W-1:0] C_17_35  = ACC_W'(((64'sd17 <<< F) + 17) / 35);
  localparam logic signed [ACC_W-1:0] C_212    = ACC_W'(((64'sd212 <<< F) + 500) / 1000);
  localparam logic signed [ACC_W-1:0] C_576    = ACC_W'(((64'sd576 <<< F) + 500) / 1000);
  localparam logic signed [ACC_W-1:0] C_11     = ACC_W'(((64'sd11 <<< F) + 50) / 100);
  localparam logic signed [ACC_W-1:0] C_24     = ACC_W'(((64'sd24 <<< F) + 50) / 100);
  localparam logic signed [ACC_W-1:0] C_3_10   = ACC_W'(((64'sd3 <<< F) + 5) / 10);
  localparam logic signed [ACC_W-1:0] C_7      = ACC_W'(((64'sd7 <<< F) + 50) / 100);
  localparam logic signed [ACC_W-1:0] C_86     = ACC_W'(((64'sd86 <<< F) + 50) / 100);
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd1 <<< (F - 1));

  logic signed [HIST_W:0]     p1;
  logic signed [HIST_W:0]     p2;
  logic signed [HIST_W+1:0]   p3;
  logic signed [ACC_W-1:0]    e1;
  logic signed [ACC_W-1:0]    e2;
  logic signed [ACC_W-1:0]    e0;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [QW-1:0]       q;
  logic [QW-COORD_BITS:0]     q_hi;
  logic signed [COORD_BITS-1:0] sat;

  assign p1 = (HIST_W+1)'(s1) + (HIST_W+1)'(r1);
  assign p2 = (HIST_W+1)'(s2) + (HIST_W+1)'(r2);
  assign p3 = (HIST_W+2)'(p1) + (HIST_W+2)'(r0);
  assign e1 = ACC_W'(p1);
  assign e2 = ACC_W'(p2);
  assign e0 = ACC_W'(r0);

  always_comb begin
    unique case (mode)
      tpsf_pkg::MODE_MEAN3:  acc = C_1_3 * ACC_W'(p3);
      tpsf_pkg::MODE_QUAD5:  acc = C_12_35 * e1 - C_3_35 * e2 + C_17_35 * e0;
      tpsf_pkg::MODE_BELL3:  acc = C_212 * e1 + C_576 * e0;
      tpsf_pkg::MODE_BELL5:  acc = C_11 * e2 + C_24 * e1 + C_3_10 * e0;
      tpsf_pkg::MODE_LIGHT3: acc = C_7 * e1 + C_86 * e0;
      default:               acc = '0;
    endcase
  end

  // round half up, then floor shift
  assign rnd  = acc + HALF_LSB;
  assign q    = rnd[ACC_W-1:F];
  assign q_hi = q[QW-1:COORD_BITS-1];

  always_comb begin
    if ((&q_hi) || !(|q_hi)) begin
      sat = q[COORD_BITS-1:0];
    end else if (q[QW-1]) begin
      sat = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  end

  assign filt = HIST_W'(sat);

endmodule

@@ hdl/tpsf_core.sv @@
// Input register, line state and per-point result generation.
module tpsf_core #(
  parameter int COORD_BITS     = tpsf_pkg::COORD_BITS_DEF,
  parameter int COEF_FRAC_BITS = tpsf_pkg::COEF_FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  tpsf_in_if.sink                     pts_in,
  input  logic                        cfg_wr_en,
  input  logic [tpsf_pkg::MODE_W-1:0] cfg_wr_data,
  input  tpsf_pkg::fifo_stat_t        fifo_stat,
  output tpsf_pkg::push_t             push
);

  localparam int HIST_W = (COORD_BITS > tpsf_pkg::IO_W) ? COORD_BITS : tpsf_pkg::IO_W;
  localparam int IO_W   = tpsf_pkg::IO_W;

  logic                   stg_valid;
  logic signed [IO_W-1:0] stg_x;
  logic signed [IO_W-1:0] stg_y;
  logic                   stg_last;
  logic                   proc;

  logic [tpsf_pkg::MODE_W-1:0] smooth_mode;
  logic [tpsf_pkg::MODE_W-1:0] line_mode;
  logic [tpsf_pkg::MODE_W-1:0] mode_eff;
  logic [tpsf_pkg::CNT_W-1:0]  points_seen;
  logic [1:0]                  h;
  logic                        emit;
  logic                        filt_ok;
  logic [1:0]                  held;

  logic signed [IO_W-1:0]   cur    [2];
  logic signed [IO_W-1:0]   rp0    [2];
  logic signed [IO_W-1:0]   rp1    [2];
  logic signed [IO_W-1:0]   rp0_next [2];
  logic signed [IO_W-1:0]   rp1_next [2];
  logic signed [IO_W-1:0]   r1_sel [2];
  logic signed [HIST_W-1:0] hist1  [2];
  logic signed [HIST_W-1:0] hist2  [2];
  logic signed [HIST_W-1:0] filt   [2];
  logic signed [HIST_W-1:0] v      [2];

  logic [1:0] slot_a;
  logic [1:0] slot_b;
  logic [1:0] cnt;
  tpsf_pkg::res_t [tpsf_pkg::MAX_RES-1:0] items;

  assign proc         = stg_valid && fifo_stat.space_ok;
  assign pts_in.ready = !stg_valid || fifo_stat.space_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (pts_in.ready) begin
      stg_valid <= pts_in.valid;
    end
    if (pts_in.ready && pts_in.valid) begin
      stg_x    <= pts_in.x_in;
      stg_y    <= pts_in.y_in;
      stg_last <= pts_in.last_in;
    end
  end

  assign cur[0]   = stg_x;
  assign cur[1]   = stg_y;
  assign mode_eff = (points_seen == '0) ? smooth_mode : line_mode;
  assign h        = tpsf_pkg::half_width(mode_eff);
  assign emit     = points_seen >= {1'b0, h};
  assign filt_ok  = points_seen >= {h, 1'b0};
  assign held     = emit ? h : (points_seen[1:0] + 2'd1);

  for (genvar a = 0; a < 2; a++) begin : g_axis
    assign r1_sel[a] = (h == 2'd2) ? rp1[a] : cur[a];

    tpsf_axis #(
      .COORD_BITS     (COORD_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_axis (
      .mode (mode_eff),
      .s2   (hist2[a]),
      .s1   (hist1[a]),
      .r0   (rp0[a]),
      .r1   (r1_sel[a]),
      .r2   (cur[a]),
      .filt (filt[a])
    );
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (h == 2'd0) begin
        v[a] = HIST_W'(cur[a]);
      end else if (filt_ok) begin
        v[a] = filt[a];
      end else begin
        v[a] = HIST_W'(rp0[a]);
      end
      rp0_next[a] = rp0[a];
      rp1_next[a] = rp1[a];
      if (emit) begin
        if (h == 2'd2) begin
          rp0_next[a] = rp1[a];
          rp1_next[a] = cur[a];
        end else if (h == 2'd1) begin
          rp0_next[a] = cur[a];
        end
      end else if (!points_seen[0]) begin
        rp0_next[a] = cur[a];
      end else begin
        rp1_next[a] = cur[a];
      end
    end
  end

  // results: smoothed point first, then held raw points on end of line
  always_comb begin
    items  = '0;
    slot_a = emit ? 2'd1 : 2'd0;
    slot_b = emit ? 2'd2 : 2'd1;
    cnt    = emit ? 2'd1 : 2'd0;
    if (emit) begin
      items[0].x    = v[0][IO_W-1:0];
      items[0].y    = v[1][IO_W-1:0];
      items[0].last = stg_last && (h == 2'd0);
    end
    if (stg_last && (held != 2'd0)) begin
      items[slot_a].x    = rp0_next[0];
      items[slot_a].y    = rp0_next[1];
      items[slot_a].last = (held == 2'd1);
      cnt                = cnt + 2'd1;
      if (held == 2'd2) begin
        items[slot_b].x    = rp1_next[0];
        items[slot_b].y    = rp1_next[1];
        items[slot_b].last = 1'b1;
        cnt                = cnt + 2'd1;
      end
    end
  end

  assign push.item = items;
  assign push.n    = proc ? cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_mode <= tpsf_pkg::MODE_RESET;
      line_mode   <= tpsf_pkg::MODE_RESET;
      points_seen <= '0;
    end else begin
      if (cfg_wr_en) begin
        smooth_mode <= cfg_wr_data;
      end
      if (proc) begin
        line_mode <= mode_eff;
        if (stg_last) begin
          points_seen <= '0;
        end else if (points_seen != tpsf_pkg::CNT_MAX) begin
          points_seen <= points_seen + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      for (int a = 0; a < 2; a++) begin
        rp0[a] <= rp0_next[a];
        rp1[a] <= rp1_next[a];
        if (emit) begin
          hist2[a] <= hist1[a];
          hist1[a] <= v[a];
        end
      end
    end
  end

endmodule

@@ hdl/tpsf_out_fifo.sv @@
// Result queue: takes up to three results a cycle, presents one.
module tpsf_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  tpsf_pkg::push_t      push,
  tpsf_out_if.source           pts_out,
  output tpsf_pkg::fifo_stat_t fifo_stat
);

  localparam int PTR_W = tpsf_pkg::PTR_W;
  localparam int LVL_W = tpsf_pkg::LVL_W;

  tpsf_pkg::res_t mem [tpsf_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [LVL_W-1:0] level;
  logic             pop;

  assign pop                = pts_out.valid && pts_out.ready;
  assign pts_out.valid      = level != '0;
  assign pts_out.x_out      = mem[rptr].x;
  assign pts_out.y_out      = mem[rptr].y;
  assign pts_out.last_out   = mem[rptr].last;
  assign fifo_stat.level    = level;
  assign fifo_stat.space_ok = level <= LVL_W'(tpsf_pkg::FIFO_DEPTH - tpsf_pkg::MAX_RES);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push.n);
      rptr  <= rptr + PTR_W'(pop);
      level <= level + LVL_W'(push.n) - LVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < tpsf_pkg::MAX_RES; k++) begin
      if (tpsf_pkg::NRES_W'(k) < push.n) begin
        mem[wptr + PTR_W'(k)] <= push.item[k];
      end
    end
  end

endmodule

@@ hdl/track_point_smoothing_filter.sv @@
// Top level of the track point smoothing filter.
//
//  channel   dir  handshake      payload
//  pts_in    in   valid/ready    x_in, y_in, last_in
//  pts_out   out  valid/ready    x_out, y_out, last_out
//  cfg       in   cfg_wr_en      cfg_wr_data (smoothing mode)
//
// One point a cycle while the queue has room: an input register, a combinational per-axis
// weighted sum with rounding and saturation, then an eight-deep result queue.
// A point that ends a line may leave up to three results in the queue.
// The input register holds its request while the queue has fewer than three free entries.
// rst clears the queue, line count and mode (light three-point).
module track_point_smoothing_filter #(
  parameter int COORD_BITS     = tpsf_pkg::COORD_BITS_DEF,
  parameter int COEF_FRAC_BITS = tpsf_pkg::COEF_FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  tpsf_in_if.sink                     pts_in,
  tpsf_out_if.source                  pts_out,
  input  logic                        cfg_wr_en,
  input  logic [tpsf_pkg::MODE_W-1:0] cfg_wr_data
);

  tpsf_pkg::push_t      push;
  tpsf_pkg::fifo_stat_t fifo_stat;
  logic                 pop;

  assign pop = pts_out.valid && pts_out.ready;

  tpsf_core #(
    .COORD_BITS     (COORD_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .pts_in      (pts_in),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fifo_stat   (fifo_stat),
    .push        (push)
  );

  tpsf_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pts_out   (pts_out),
    .fifo_stat (fifo_stat)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_stat.level <= tpsf_pkg::LVL_W'(tpsf_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != '0) |-> fifo_stat.space_ok)
    else $error("results pushed without room");

  a_level_track: assert property (@(posedge clk) disable iff (rst)
    ((push.n != '0) && !pop) |=>
      (fifo_stat.level == $past(fifo_stat.level) + tpsf_pkg::LVL_W'($past(push.n))))
    else $error("queue level does not follow pushes");

  a_reset_empty: assert property (@(posedge clk) rst |=> !pts_out.valid)
    else $error("results shown after reset");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the track point smoothing filter.
module tb;

  localparam int MODE_W = tpsf_pkg::MODE_W;
  localparam int IO_W   = tpsf_pkg::IO_W;
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
  localparam logic signed [IO_W-1:0] COORD_MAX = {1'b0, {(IO_W-1){1'b1}}};
  localparam logic signed [IO_W-1:0] COORD_MIN = {1'b1, {(IO_W-1){1'b0}}};
  localparam int FRAC          = tpsf_pkg::COEF_FRAC_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_POINTS = 230;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [MODE_W-1:0] cfg_wr_data;

  tpsf_in_if  pts_in_ch ();
  tpsf_out_if pts_out_ch ();

  track_point_smoothing_filter dut (
    .clk         (clk),
    .rst         (rst),
    .pts_in      (pts_in_ch),
    .pts_out     (pts_out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // filter state as the block should hold it
  logic [MODE_W-1:0] mode_cfg;
  logic [MODE_W-1:0] mode_line;
  longint smoothed[2][2];  // [age][axis]
  longint pending[2][2];   // [slot][axis]
  int unsigned seen;

  tpsf_pkg::res_t expected_points[$];
  int mismatch_count = 0;
  int idle_cycles;
  bit in_idle_en;
  bit out_idle_en;
  int stall_left;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int window_half(logic [MODE_W-1:0] m);
    case (m)
      tpsf_pkg::MODE_MEAN3, tpsf_pkg::MODE_BELL3, tpsf_pkg::MODE_LIGHT3: return 1;
      tpsf_pkg::MODE_QUAD5, tpsf_pkg::MODE_BELL5: return 2;
      default: return 0;
    endcase
  endfunction

  function automatic longint qcoef(longint n, longint d);
    return ((n <<< FRAC) + d / 2) / d;
  endfunction

  function automatic longint round_sat(longint acc);
    longint q;
    q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (q > longint'(COORD_MAX)) return longint'(COORD_MAX);
    if (q < longint'(COORD_MIN)) return longint'(COORD_MIN);
    return q;
  endfunction

  function automatic longint smooth_axis(logic [MODE_W-1:0] m, longint s2, longint s1,
                                         longint r0, longint r1, longint r2);
    longint acc;
    case (m)
      tpsf_pkg::MODE_MEAN3:  acc = qcoef(1, 3) * (s1 + r0 + r1);
      tpsf_pkg::MODE_QUAD5:  acc = qcoef(12, 35) * (s1 + r1) - qcoef(3, 35) * (s2 + r2)
                                   + qcoef(17, 35) * r0;
      tpsf_pkg::MODE_BELL3:  acc = qcoef(212, 1000) * (s1 + r1) + qcoef(576, 1000) * r0;
      tpsf_pkg::MODE_BELL5:  acc = qcoef(11, 100) * (s2 + r2) + qcoef(24, 100) * (s1 + r1)
                                   + qcoef(3, 10) * r0;
      tpsf_pkg::MODE_LIGHT3: acc = qcoef(7, 100) * (s1 + r1) + qcoef(86, 100) * r0;
      default:               return r0;
    endcase
    return round_sat(acc);
  endfunction

  function automatic void push_point(longint px, longint py, logic ends_line);
    tpsf_pkg::res_t p;
    p.x = px[IO_W-1:0];
    p.y = py[IO_W-1:0];
    p.last = ends_line;
    expected_points.insert(expected_points.size(), p);
  endfunction

  // one accepted request: update state, queue whatever it releases
  function automatic void smooth_track_point(logic signed [IO_W-1:0] px,
                                             logic signed [IO_W-1:0] py,
                                             logic ends_line);
    longint cur[2];
    longint v[2];
    int h;
    int c;
    int held;
    cur[0] = px;
    cur[1] = py;
    if (seen == 0) mode_line = mode_cfg;
    h = window_half(mode_line);
    c = seen;
    if (c >= h) begin
      for (int a = 0; a < 2; a++) begin
        if (h == 0) v[a] = cur[a];
        else if (c >= 2 * h)
          v[a] = smooth_axis(mode_line, smoothed[1][a], smoothed[0][a], pending[0][a],
                             (h == 2) ? pending[1][a] : cur[a], cur[a]);
        else v[a] = pending[0][a];
        smoothed[1][a] = smoothed[0][a];
        smoothed[0][a] = v[a];
        if (h == 2) begin
          pending[0][a] = pending[1][a];
          pending[1][a] = cur[a];
        end else if (h == 1) begin
          pending[0][a] = cur[a];
        end
      end
      push_point(v[0], v[1], ends_line && (h == 0));
      held = h;
    end else begin
      pending[c & 1][0] = cur[0];
      pending[c & 1][1] = cur[1];
      held = c + 1;
    end
    if (ends_line) begin
      for (int k = 0; k < held && k < 2; k++)
        push_point(pending[k][0], pending[k][1], (k + 1) == held);
      seen = 0;
    end else if (seen < 7) begin
      seen++;
    end
  endfunction

  task automatic send_point(input logic signed [IO_W-1:0] px,
                            input logic signed [IO_W-1:0] py,
                            input logic ends_line);
    int gap;
    gap = in_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      pts_in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pts_in_ch.valid   <= 1'b1;
    pts_in_ch.x_in    <= px;
    pts_in_ch.y_in    <= py;
    pts_in_ch.last_in <= ends_line;
    @(posedge clk);
    while (!pts_in_ch.ready) @(posedge clk);
    smooth_track_point(px, py, ends_line);
  endtask

  task automatic drain_results();
    pts_in_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_smoothing_mode(input logic [MODE_W-1:0] m);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_cfg = m;
  endtask

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return tpsf_pkg::MODE_MEAN3;
    if (r < 25) return MODE_SPARE7;
    return MODE_W'($urandom_range(0, 7));
  endfunction

  function automatic logic signed [IO_W-1:0] rand_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return int'($urandom_range(0, 4000)) - 2000;
      2: begin
        case ($urandom_range(0, 5))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return COORD_MAX - $urandom_range(0, 1000);
          3: return COORD_MIN + $urandom_range(0, 1000);
          default: return $urandom;
        endcase
      end
      default: return ($urandom_range(0, 1) != 0) ? $urandom
                                                  : int'($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  // output side: random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      stall_left       <= 0;
      pts_out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pts_out_ch.ready <= 1'b0;
    end else begin
      pts_out_ch.ready <= 1'b1;
      if (out_idle_en && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    tpsf_pkg::res_t want;
    if (!rst && pts_out_ch.valid && pts_out_ch.ready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result x_out=%0d y_out=%0d last_out=%0b",
               pts_out_ch.x_out, pts_out_ch.y_out, pts_out_ch.last_out);
        mismatch_count++;
      end else begin
        want = expected_points.pop_front();
        if (pts_out_ch.x_out !== want.x) begin
          $error("x_out mismatch: expected %0d, got %0d", want.x, pts_out_ch.x_out);
          mismatch_count++;
        end
        if (pts_out_ch.y_out !== want.y) begin
          $error("y_out mismatch: expected %0d, got %0d", want.y, pts_out_ch.y_out);
          mismatch_count++;
        end
        if (pts_out_ch.last_out !== want.last) begin
          $error("last_out mismatch: expected %0b, got %0b", want.last,
                 pts_out_ch.last_out);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pts_in_ch.valid && pts_in_ch.ready) ||
        (pts_out_ch.valid && pts_out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_single_point();
    send_point(COORD_MAX, COORD_MIN, 1'b1);
  endtask

  // quad5 window is five points; three points pass unchanged
  task automatic test_short_line();
    set_smoothing_mode(tpsf_pkg::MODE_QUAD5);
    send_point(32'sd17, -32'sd5, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 1'b0);
    send_point(-32'sd1, 32'sd0, 1'b1);
  endtask

  task automatic test_saturation();
    send_point(COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 1'b1);
  endtask

  task automatic test_mean3();
    set_smoothing_mode(tpsf_pkg::MODE_MEAN3);
    send_point(COORD_MAX, -32'sd1, 1'b0);
    send_point(COORD_MAX, 32'sd0, 1'b0);
    send_point(COORD_MAX, 32'sd2, 1'b1);
  endtask

  // mode change mid-line only applies from the next line
  task automatic test_mode_mid_line();
    set_smoothing_mode(tpsf_pkg::MODE_BELL3);
    send_point(32'sd1000, -32'sd3000, 1'b0);
    send_point(-32'sd7000, 32'sd123456, 1'b0);
    set_smoothing_mode(tpsf_pkg::MODE_BELL5);
    send_point(32'sd55555, -32'sd99, 1'b0);
    send_point(32'sd4, 32'sd77, 1'b1);
    send_point(32'sd100, 32'sd200, 1'b0);
    send_point(-32'sd300, 32'sd400, 1'b0);
    send_point(32'sd500000, -32'sd600000, 1'b0);
    send_point(32'sd7, 32'sd8, 1'b0);
    send_point(-32'sd9, 32'sd10, 1'b1);
  endtask

  task automatic test_pass_modes();
    set_smoothing_mode(tpsf_pkg::MODE_PASS);
    send_point(32'sd42, COORD_MIN, 1'b1);
    set_smoothing_mode(MODE_SPARE7);
    send_point(COORD_MAX, -32'sd42, 1'b1);
    set_smoothing_mode(MODE_SPARE6);
    send_point(-32'sd1, 32'sd1, 1'b1);
    set_smoothing_mode(tpsf_pkg::MODE_LIGHT3);
    send_point(32'sd90000, -32'sd90000, 1'b0);
    send_point(-32'sd12345, 32'sd54321, 1'b0);
    send_point(32'sd65536, 32'sd3, 1'b1);
  endtask

  task automatic test_random_lines();
    int sent;
    int len;
    int split;
    int r;
    int kind;
    sent = 0;
    while (sent < RANDOM_POINTS) begin
      in_idle_en  = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) set_smoothing_mode(pick_mode());
      r = $urandom_range(0, 99);
      if (r < 12) len = $urandom_range(1, 2);
      else if (r < 88) len = $urandom_range(3, 10);
      else len = $urandom_range(11, 20);
      split = (len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : 0;
      kind = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        if (split != 0 && i == split) set_smoothing_mode(pick_mode());
        send_point(rand_coord(kind), rand_coord(kind), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= tpsf_pkg::MODE_RESET;
    pts_in_ch.valid   <= 1'b0;
    pts_in_ch.x_in    <= '0;
    pts_in_ch.y_in    <= '0;
    pts_in_ch.last_in <= 1'b0;
    in_idle_en     = 1'b1;
    out_idle_en    = 1'b1;
    mode_cfg       = tpsf_pkg::MODE_RESET;
    mode_line      = tpsf_pkg::MODE_RESET;
    seen           = 0;
    smoothed       = '{default: 0};
    pending        = '{default: 0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_point();
    test_short_line();
    test_saturation();
    test_mean3();
    test_mode_mid_line();
    test_pass_modes();
    test_random_lines();
    drain_results();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
